// ===== rtl/tcrs_pkg.sv =====
// Shared types and constants of the two-class request scheduler.
// No dependencies; every rtl file refers to it by scoped names.
package tcrs_pkg;

  localparam int DEPTH   = 8;
  localparam int ID_BITS = 16;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_ADD_REG = 2'd0,
    KIND_ADD_PRI = 2'd1,
    KIND_SERVE   = 2'd2,
    KIND_DEMOTE  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_REG_FULL  = 3'd1,
    STAT_PRI_FULL  = 3'd2,
    STAT_NO_SERVE  = 3'd3,
    STAT_NO_DEMOTE = 3'd4,
    STAT_DROPPED   = 3'd5
  } status_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] req_id;
    logic        urgent;
  } in_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] out_id;
    logic        from_priority;
    logic        out_urgent;
  } out_t;

  typedef enum logic {
    CTL_EMPTY = 1'b0,
    CTL_HOLD  = 1'b1
  } ctl_state_t;

  typedef struct packed {
    logic exec;
  } dp_cmd_t;

  typedef struct packed {
    logic reg_full;
    logic pri_full;
  } dp_stat_t;

endpackage

// ===== rtl/tcrs_ctrl.sv =====
// Handshake controller of the scheduler: tracks the result register.
// Depends on tcrs_pkg; drives the datapath through tcrs_pkg::dp_cmd_t.
module tcrs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  tcrs_pkg::dp_stat_t stat,
  output tcrs_pkg::dp_cmd_t  cmd
);

  tcrs_pkg::ctl_state_t state_r;
  tcrs_pkg::ctl_state_t state_nxt;
  logic                 exec;

  assign exec = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tcrs_pkg::CTL_EMPTY: begin
        if (exec) state_nxt = tcrs_pkg::CTL_HOLD;
      end
      tcrs_pkg::CTL_HOLD: begin
        if (!exec && !out_stall) state_nxt = tcrs_pkg::CTL_EMPTY;
      end
      default: state_nxt = tcrs_pkg::CTL_EMPTY;
    endcase
  end

  always_comb begin
    in_stall  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      tcrs_pkg::CTL_EMPTY: begin
        in_stall  = 1'b0;
        out_valid = 1'b0;
      end
      tcrs_pkg::CTL_HOLD: begin
        in_stall  = out_stall;
        out_valid = 1'b1;
      end
      default: begin
        in_stall  = 1'b1;
        out_valid = 1'b0;
      end
    endcase
    cmd.exec = in_valid && !in_stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tcrs_pkg::CTL_EMPTY;
    end else begin
      state_r <= state_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tcrs_pkg::CTL_HOLD && out_stall) |=> (state_r == tcrs_pkg::CTL_HOLD))
    else $error("held result lost under stall");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> (state_r == tcrs_pkg::CTL_HOLD))
    else $error("transfer in did not load result");
  assert property (@(posedge clk) disable iff (!rst_n)
    (stat.reg_full && stat.pri_full) |-> (stat.reg_full == stat.pri_full))
    else $error("status mismatch");

endmodule

// ===== rtl/tcrs_dp.sv =====
// Datapath of the scheduler: regular FIFO, ordered priority shift queue,
// result register. Depends on tcrs_pkg; controlled by tcrs_ctrl.
module tcrs_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  tcrs_pkg::dp_cmd_t  cmd,
  input  tcrs_pkg::in_t      in_data,
  output tcrs_pkg::out_t     out_data,
  output tcrs_pkg::dp_stat_t stat
);

  localparam int IW = tcrs_pkg::ID_BITS;
  localparam int XW = tcrs_pkg::IDX_W;
  localparam int CW = tcrs_pkg::CNT_W;
  localparam int D  = tcrs_pkg::DEPTH;

  logic [IW-1:0] reg_mem_r [D];
  logic [XW-1:0] head_r, head_nxt;
  logic [CW-1:0] reg_count_r, reg_count_nxt;
  logic [CW-1:0] pri_count_r, pri_count_nxt;
  logic [CW-1:0] urg_count_r, urg_count_nxt;
  logic [IW-1:0] pq_id_r  [D];
  logic          pq_urg_r [D];
  logic [IW-1:0] pq_id_nxt  [D];
  logic          pq_urg_nxt [D];
  tcrs_pkg::out_t out_r, res;

  logic [IW-1:0] in_id;
  logic          reg_full, reg_empty, pri_full, pri_empty;
  logic [CW:0]   tail_sum;
  logic [XW-1:0] tail;
  logic [XW-1:0] head_inc;
  logic          push_en, pop_reg, pq_ins, pq_pop;
  logic [IW-1:0] push_id;
  logic [CW-1:0] ins_pos;

  assign in_id     = IW'(in_data.req_id);
  assign reg_full  = (reg_count_r == CW'(D));
  assign reg_empty = (reg_count_r == '0);
  assign pri_full  = (pri_count_r == CW'(D));
  assign pri_empty = (pri_count_r == '0);
  assign stat.reg_full = reg_full;
  assign stat.pri_full = pri_full;

  assign tail_sum = (CW+1)'(head_r) + (CW+1)'(reg_count_r);
  assign tail     = (tail_sum >= (CW+1)'(D)) ? XW'(tail_sum - (CW+1)'(D)) : XW'(tail_sum);
  assign head_inc = (head_r == XW'(D - 1)) ? '0 : head_r + 1'b1;
  assign ins_pos  = in_data.urgent ? urg_count_r : pri_count_r;

  always_comb begin
    push_en = 1'b0;
    pop_reg = 1'b0;
    pq_ins  = 1'b0;
    pq_pop  = 1'b0;
    push_id = in_id;
    res.status        = tcrs_pkg::STAT_OK;
    res.out_id        = '0;
    res.from_priority = 1'b0;
    res.out_urgent    = 1'b0;
    case (in_data.kind)
      tcrs_pkg::KIND_ADD_REG: begin
        if (reg_full) res.status = tcrs_pkg::STAT_REG_FULL;
        else push_en = 1'b1;
      end
      tcrs_pkg::KIND_ADD_PRI: begin
        if (pri_full) res.status = tcrs_pkg::STAT_PRI_FULL;
        else pq_ins = 1'b1;
      end
      tcrs_pkg::KIND_SERVE: begin
        if (!pri_empty) begin
          pq_pop            = 1'b1;
          res.out_id        = 16'(pq_id_r[0]);
          res.from_priority = 1'b1;
          res.out_urgent    = pq_urg_r[0];
        end else if (!reg_empty) begin
          pop_reg    = 1'b1;
          res.out_id = 16'(reg_mem_r[head_r]);
        end else begin
          res.status = tcrs_pkg::STAT_NO_SERVE;
        end
      end
      tcrs_pkg::KIND_DEMOTE: begin
        if (pri_empty) begin
          res.status = tcrs_pkg::STAT_NO_DEMOTE;
        end else begin
          pq_pop     = 1'b1;
          res.out_id = 16'(pq_id_r[0]);
          push_id    = pq_id_r[0];
          if (reg_full) res.status = tcrs_pkg::STAT_DROPPED;
          else push_en = 1'b1;
        end
      end
      default: res.status = tcrs_pkg::STAT_OK;
    endcase
  end

  for (genvar g = 0; g < D; g++) begin : g_slot
    always_comb begin
      pq_id_nxt[g]  = pq_id_r[g];
      pq_urg_nxt[g] = pq_urg_r[g];
      if (pq_ins) begin
        if (CW'(g) == ins_pos) begin
          pq_id_nxt[g]  = in_id;
          pq_urg_nxt[g] = in_data.urgent;
        end else if (CW'(g) > ins_pos) begin
          if (g > 0) begin
            pq_id_nxt[g]  = pq_id_r[(g > 0) ? g - 1 : 0];
            pq_urg_nxt[g] = pq_urg_r[(g > 0) ? g - 1 : 0];
          end
        end
      end else if (pq_pop) begin
        if (g < D - 1) begin
          pq_id_nxt[g]  = pq_id_r[(g < D - 1) ? g + 1 : g];
          pq_urg_nxt[g] = pq_urg_r[(g < D - 1) ? g + 1 : g];
        end
      end
    end
  end

  always_comb begin
    head_nxt      = pop_reg ? head_inc : head_r;
    reg_count_nxt = reg_count_r;
    if (push_en) reg_count_nxt = reg_count_r + 1'b1;
    else if (pop_reg) reg_count_nxt = reg_count_r - 1'b1;
    pri_count_nxt = pri_count_r;
    urg_count_nxt = urg_count_r;
    if (pq_ins) begin
      pri_count_nxt = pri_count_r + 1'b1;
      if (in_data.urgent) urg_count_nxt = urg_count_r + 1'b1;
    end else if (pq_pop) begin
      pri_count_nxt = pri_count_r - 1'b1;
      if (urg_count_r != '0) urg_count_nxt = urg_count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      reg_count_r <= '0;
      pri_count_r <= '0;
      urg_count_r <= '0;
    end else if (cmd.exec) begin
      head_r      <= head_nxt;
      reg_count_r <= reg_count_nxt;
      pri_count_r <= pri_count_nxt;
      urg_count_r <= urg_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_r <= res;
      if (push_en) reg_mem_r[tail] <= push_id;
      for (int k = 0; k < D; k++) begin
        pq_id_r[k]  <= pq_id_nxt[k];
        pq_urg_r[k] <= pq_urg_nxt[k];
      end
    end
  end

  assign out_data = out_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    (reg_count_r <= CW'(D)) && (pri_count_r <= CW'(D)))
    else $error("queue count beyond depth");
  assert property (@(posedge clk) disable iff (!rst_n)
    urg_count_r <= pri_count_r)
    else $error("urgent count exceeds priority count");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && in_data.kind == tcrs_pkg::KIND_SERVE && !pri_empty)
      |=> out_r.from_priority)
    else $error("serve skipped nonempty priority queue");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && push_en) |=> (reg_count_r != '0))
    else $error("push left FIFO empty");

endmodule

// ===== rtl/two_class_request_scheduler_top.sv =====
// Top level of the two-class request scheduler.
// Depends on tcrs_pkg, tcrs_ctrl and tcrs_dp.
//
//   channel  ports                          payload
//   in       in_valid, in_stall, in_data     tcrs_pkg::in_t  (kind, req_id, urgent)
//   out      out_valid, out_stall, out_data  tcrs_pkg::out_t (status, out_id, ...)
//
// One command per cycle: each transfer in executes in the cycle it is taken,
// priority inserts shift every slot behind the insert point in parallel.
// Its single result appears in the result register on the next cycle.
// A new command is taken while the result register is empty or being drained.
// Reset (rst_n low, synchronous) empties both queues; no clearing pass.
module two_class_request_scheduler_top (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  tcrs_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output tcrs_pkg::out_t out_data
);

  tcrs_pkg::dp_cmd_t  cmd;
  tcrs_pkg::dp_stat_t stat;

  tcrs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  tcrs_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data),
    .stat     (stat)
  );

endmodule
